@@ sv/bfdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bfdt_pkg
// Shared widths, codes and types of the data tape unit.
// ----------------------------------------------------------------------------
package bfdt_pkg;

    localparam int DEF_TAPE_DEPTH = 4096;

    localparam int DATA_W     = 32;
    localparam int ALU_W      = DATA_W + 1;
    localparam int CFG_LEN_W  = 13;
    localparam int PTR_OUT_W  = 12;
    localparam int REQ_W      = 3;
    localparam int ERR_W      = 2;
    localparam int CW_W       = 2;
    localparam int PADDR_W    = 4;
    localparam int DIV_STEPS  = DATA_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SUB   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RIGHT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LEFT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STORE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_EMIT  = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RIGHT = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LEFT  = 2'd2;

    localparam logic [CW_W-1:0] CW_8  = 2'd0;
    localparam logic [CW_W-1:0] CW_16 = 2'd1;

    localparam logic [1:0] REG_TAPE_LENGTH = 2'd0;
    localparam logic [1:0] REG_TAPE_MODE   = 2'd1;
    localparam logic [1:0] REG_EOF_MODE    = 2'd2;
    localparam logic [1:0] REG_CELL_WIDTH  = 2'd3;

    localparam logic [CFG_LEN_W-1:0] TAPE_LENGTH_RST = 13'd4096;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             carry;
        logic [ALU_W-1:0] sum;
    } alu_res_t;

endpackage

@@ sv/bfdt_alu.sv @@
// ----------------------------------------------------------------------------
// bfdt_alu
// Shared add/subtract unit; carry out set on add overflow or on a
// subtract without borrow.
// ----------------------------------------------------------------------------
module bfdt_alu (
    input  bfdt_pkg::alu_req_t req,
    output bfdt_pkg::alu_res_t res
);
    import bfdt_pkg::*;

    logic [ALU_W:0] full;

    always_comb
    begin
        full = {1'b0, req.a} + {1'b0, req.b ^ {ALU_W{req.sub}}}
             + {{ALU_W{1'b0}}, req.sub};
        res.carry = full[ALU_W];
        res.sum   = full[ALU_W-1:0];
    end

endmodule

@@ sv/bf_data_tape_unit.sv @@
// ----------------------------------------------------------------------------
// bf_data_tape_unit
// Data tape with pointer: cell add/subtract, moves, store and emit.
// ----------------------------------------------------------------------------
// After reset the tape is cleared one cell per cycle with in_stall high;
// configuration writes are taken meanwhile. One word is worked at a time on a
// single shared adder. Add, subtract, store, emit and unused codes pass
// through the read, calc and done states; a limited-mode move first clamps the
// pointer in the limit state, and a continuous-mode move first runs the 32-step
// restoring remainder (move count modulo tape length) on the shared adder,
// then the wrap states. A result waits in the output register while the next
// word is worked; the unit only holds in its last state if that register is still occupied.
module bf_data_tape_unit #(
    parameter int TAPE_DEPTH = bfdt_pkg::DEF_TAPE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfdt_pkg::PADDR_W-1:0]      paddr,
    input  logic [bfdt_pkg::DATA_W-1:0]       pwdata,
    output logic [bfdt_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bfdt_pkg::REQ_W-1:0]        req_type,
    input  logic signed [bfdt_pkg::DATA_W-1:0] amount,
    input  logic [bfdt_pkg::DATA_W-1:0]       in_value,
    input  logic                              at_eof,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bfdt_pkg::DATA_W-1:0]       cell_value,
    output logic [bfdt_pkg::PTR_OUT_W-1:0]    pointer_pos,
    output logic [bfdt_pkg::ERR_W-1:0]        range_error,
    output logic                              emit_strobe
);
    import bfdt_pkg::*;

    localparam int PTR_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
    localparam int LEN_W = PTR_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_LIM,
        ST_DIV,
        ST_WRAP1,
        ST_WRAP2,
        ST_RD,
        ST_CALC,
        ST_DONE
    } state_t;

    // configuration
    logic [CFG_LEN_W-1:0] tape_length_reg;
    logic                 tape_mode_reg;
    logic                 eof_mode_reg;
    logic [CW_W-1:0]      cell_width_reg;
    logic                 cfg_wr;

    // sequencer and datapath
    state_t               state_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     clr_cnt_reg;
    logic [REQ_W-1:0]     req_reg;
    logic [DATA_W-1:0]    amt_reg;
    logic [DATA_W-1:0]    val_reg;
    logic                 eof_reg;
    logic [DATA_W-1:0]    n_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [LEN_W:0]       wrap_reg;
    logic                 wrap_neg_reg;
    logic [ERR_W-1:0]     err_reg;
    logic [DATA_W-1:0]    res_cell_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    cell_value_reg;
    logic [PTR_OUT_W-1:0] pointer_pos_reg;
    logic [ERR_W-1:0]     range_error_reg;
    logic                 emit_strobe_reg;

    // tape memory
    logic [DATA_W-1:0]    tape_mem [TAPE_DEPTH];
    logic [DATA_W-1:0]    rd_data_reg;
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [DATA_W-1:0]    mem_wdata;

    logic [LEN_W-1:0]     len;
    logic [PTR_W-1:0]     last;
    logic [DATA_W-1:0]    mask;
    logic [DATA_W-1:0]    move_n;
    logic [DATA_W-1:0]    new_cell;
    logic                 cell_write;
    logic [LEN_W:0]       div_trial;
    logic [DATA_W-1:0]    ptr_ext;
    logic                 in_take;
    logic                 out_free;

    alu_req_t             alu_req;
    alu_res_t             alu_res;

    bfdt_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_length_reg <= TAPE_LENGTH_RST;
            tape_mode_reg   <= 1'b0;
            eof_mode_reg    <= 1'b0;
            cell_width_reg  <= CW_8;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_TAPE_LENGTH: tape_length_reg <= pwdata[CFG_LEN_W-1:0];
                REG_TAPE_MODE:   tape_mode_reg   <= pwdata[0];
                REG_EOF_MODE:    eof_mode_reg    <= pwdata[0];
                REG_CELL_WIDTH:  cell_width_reg  <= pwdata[CW_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TAPE_LENGTH: prdata = DATA_W'(tape_length_reg);
            REG_TAPE_MODE:   prdata = DATA_W'(tape_mode_reg);
            REG_EOF_MODE:    prdata = DATA_W'(eof_mode_reg);
            REG_CELL_WIDTH:  prdata = DATA_W'(cell_width_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // derived settings
    // ------------------------------------------------------------------
    always_comb
    begin
        if (tape_length_reg == '0)
            len = LEN_W'(1);
        else if (32'(tape_length_reg) > 32'(TAPE_DEPTH))
            len = LEN_W'(TAPE_DEPTH);
        else
            len = LEN_W'(tape_length_reg);
    end

    assign last = PTR_W'(len - LEN_W'(1));

    always_comb
    begin
        case (cell_width_reg)
            CW_8:    mask = 32'h0000_00FF;
            CW_16:   mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    assign move_n    = (amt_reg == '0 || amt_reg[DATA_W-1]) ? DATA_W'(1) : amt_reg;
    assign div_trial = {rem_reg, n_reg[DATA_W-1]};
    assign ptr_ext   = DATA_W'(ptr_reg);

    // ------------------------------------------------------------------
    // shared adder operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        alu_req.sub = 1'b0;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (state_reg)
            ST_LIM:
            begin
                if (req_reg == REQ_LEFT)
                begin
                    alu_req.sub = 1'b1;
                    alu_req.a   = ALU_W'(ptr_reg);
                    alu_req.b   = ALU_W'(n_reg);
                end
                else
                begin
                    alu_req.a   = ALU_W'(n_reg);
                    alu_req.b   = ALU_W'(ptr_reg);
                end
            end
            ST_DIV:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = ALU_W'(div_trial);
                alu_req.b   = ALU_W'(len);
            end
            ST_WRAP1:
            begin
                alu_req.sub = (req_reg == REQ_LEFT);
                alu_req.a   = ALU_W'(ptr_reg);
                alu_req.b   = ALU_W'(rem_reg);
            end
            ST_WRAP2:
            begin
                alu_req.sub = !((req_reg == REQ_LEFT) && wrap_neg_reg);
                alu_req.a   = ALU_W'(wrap_reg);
                alu_req.b   = ALU_W'(len);
            end
            ST_CALC:
            begin
                alu_req.sub = (req_reg == REQ_SUB);
                alu_req.a   = ALU_W'(rd_data_reg);
                alu_req.b   = ALU_W'(amt_reg);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // cell update
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_write = 1'b0;
        case (req_reg)
            REQ_ADD, REQ_SUB:
            begin
                new_cell   = alu_res.sum[DATA_W-1:0] & mask;
                cell_write = 1'b1;
            end
            REQ_STORE:
            begin
                if (eof_reg)
                    new_cell = eof_mode_reg ? mask : '0;
                else
                    new_cell = val_reg & mask;
                cell_write = 1'b1;
            end
            default: new_cell = rd_data_reg & mask;
        endcase
    end

    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_CALC) && cell_write);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : ptr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : new_cell;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tape_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= tape_mem[ptr_reg];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            ptr_reg         <= '0;
            clr_cnt_reg     <= '0;
            req_reg         <= REQ_ADD;
            amt_reg         <= '0;
            val_reg         <= '0;
            eof_reg         <= 1'b0;
            n_reg           <= '0;
            rem_reg         <= '0;
            div_cnt_reg     <= '0;
            wrap_reg        <= '0;
            wrap_neg_reg    <= 1'b0;
            err_reg         <= ERR_NONE;
            res_cell_reg    <= '0;
            out_valid_reg   <= 1'b0;
            cell_value_reg  <= '0;
            pointer_pos_reg <= '0;
            range_error_reg <= ERR_NONE;
            emit_strobe_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + PTR_W'(1);
                    if (clr_cnt_reg == PTR_W'(TAPE_DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        req_reg <= req_type;
                        amt_reg <= amount;
                        val_reg <= in_value;
                        eof_reg <= at_eof;
                        err_reg <= ERR_NONE;
                        if (req_type == REQ_RIGHT || req_type == REQ_LEFT)
                            state_reg <= ST_MOVE;
                        else
                            state_reg <= ST_RD;
                    end
                end
                ST_MOVE:
                begin
                    if (ptr_reg > last)
                        ptr_reg <= last;
                    n_reg       <= move_n;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= tape_mode_reg ? ST_DIV : ST_LIM;
                end
                ST_LIM:
                begin
                    if (req_reg == REQ_LEFT)
                    begin
                        if (!alu_res.carry)
                        begin
                            ptr_reg <= '0;
                            err_reg <= ERR_LEFT;
                        end
                        else
                            ptr_reg <= alu_res.sum[PTR_W-1:0];
                    end
                    else
                    begin
                        if (alu_res.sum > ALU_W'(last))
                        begin
                            ptr_reg <= last;
                            err_reg <= ERR_RIGHT;
                        end
                        else
                            ptr_reg <= alu_res.sum[PTR_W-1:0];
                    end
                    state_reg <= ST_RD;
                end
                ST_DIV:
                begin
                    if (alu_res.carry)
                        rem_reg <= alu_res.sum[LEN_W-1:0];
                    else
                        rem_reg <= div_trial[LEN_W-1:0];
                    n_reg       <= {n_reg[DATA_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                        state_reg <= ST_WRAP1;
                end
                ST_WRAP1:
                begin
                    wrap_reg     <= alu_res.sum[LEN_W:0];
                    wrap_neg_reg <= !alu_res.carry;
                    state_reg    <= ST_WRAP2;
                end
                ST_WRAP2:
                begin
                    if (req_reg == REQ_LEFT)
                    begin
                        if (wrap_neg_reg)
                            ptr_reg <= alu_res.sum[PTR_W-1:0];
                        else
                            ptr_reg <= wrap_reg[PTR_W-1:0];
                    end
                    else
                    begin
                        if (alu_res.carry)
                            ptr_reg <= alu_res.sum[PTR_W-1:0];
                        else
                            ptr_reg <= wrap_reg[PTR_W-1:0];
                    end
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    res_cell_reg <= new_cell;
                    state_reg    <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        cell_value_reg  <= res_cell_reg;
                        pointer_pos_reg <= ptr_ext[PTR_OUT_W-1:0];
                        range_error_reg <= err_reg;
                        emit_strobe_reg <= (req_reg == REQ_EMIT);
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_value  = cell_value_reg;
    assign pointer_pos = pointer_pos_reg;
    assign range_error = range_error_reg;
    assign emit_strobe = emit_strobe_reg;

`ifndef SYNTH
    a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < len)
        else $error("remainder not below tape length");

    a_right_err_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && err_reg == ERR_RIGHT) |-> ptr_reg == last)
        else $error("right range error with pointer off last cell");

    a_left_err_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && err_reg == ERR_LEFT) |-> ptr_reg == '0)
        else $error("left range error with pointer off first cell");

    a_emit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && emit_strobe) |-> range_error == ERR_NONE)
        else $error("emit word carries a range error");
`endif

endmodule

@@ tb/tb_bf_data_tape_unit.sv @@
// ----------------------------------------------------------------------------
// tb_bf_data_tape_unit
// Self-checking bench for the data tape unit.
// A directed table hits the field extremes, every request code, and the edge
// cases: overruns in limited mode, wrap in continuous mode, the clamped and
// zero tape lengths, a pointer left beyond a shortened tape, the spare width
// and request codes, and end-of-input stores. Random phases then run under
// several register settings and idle patterns on both channels. Every result
// word is checked field by field, on a row's values or an in-bench tape model.
// ----------------------------------------------------------------------------
module tb_bf_data_tape_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bfdt_pkg::*;

    localparam int DEPTH          = DEF_TAPE_DEPTH;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
    localparam logic [CW_W-1:0]  CW_32      = 2'd2;
    localparam logic [CW_W-1:0]  CW_SPARE   = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0]    cval;
        logic [PTR_OUT_W-1:0] pos;
        logic [ERR_W-1:0]     err;
        logic                 strobe;
    } tape_result_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] amt;
        logic [DATA_W-1:0] val;
        logic              eof;
        logic              chk;
        tape_result_t      want;
        logic [1:0]        reg_idx;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic [REQ_W-1:0]        req_type;
    logic signed [DATA_W-1:0] amount;
    logic [DATA_W-1:0]       in_value;
    logic                    at_eof;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [DATA_W-1:0]       cell_value;
    logic [PTR_OUT_W-1:0]    pointer_pos;
    logic [ERR_W-1:0]        range_error;
    logic                    emit_strobe;

    bf_data_tape_unit #(.TAPE_DEPTH(DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .amount     (amount),
        .in_value   (in_value),
        .at_eof     (at_eof),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_value (cell_value),
        .pointer_pos(pointer_pos),
        .range_error(range_error),
        .emit_strobe(emit_strobe)
    );

    // tape model state
    logic [DATA_W-1:0]    tape_mirror [DEPTH];
    logic [IDX_W-1:0]     head;
    logic [CFG_LEN_W-1:0] len_reg;
    logic                 wrap_reg;
    logic                 eof_reg;
    logic [CW_W-1:0]      cw_reg;

    tape_result_t result_q[$];
    dir_row_t     dir_tab[$];

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int n_errors      = 0;
    int n_words       = 0;
    int n_results     = 0;
    int n_range_errs  = 0;
    int n_emits       = 0;
    int n_reg_writes  = 0;
    int idle_cycles   = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned cells_in_use();
        if (len_reg == '0)
            return 1;
        if (32'(len_reg) > DEPTH)
            return DEPTH;
        return 32'(len_reg);
    endfunction

    function automatic logic [DATA_W-1:0] width_mask();
        case (cw_reg)
            CW_8:    return 32'h0000_00FF;
            CW_16:   return 32'h0000_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [ERR_W-1:0] move_head(logic right, logic [DATA_W-1:0] amt);
        longint unsigned len;
        longint unsigned n;
        longint unsigned p;
        logic [ERR_W-1:0] err;
        len = 64'(cells_in_use());
        n   = (amt == '0 || amt[DATA_W-1]) ? 64'd1 : 64'(amt);
        p   = 64'(head);
        err = ERR_NONE;
        if (p > len - 1)
            p = len - 1;
        if (wrap_reg)
        begin
            if (right)
                p = (p + n % len) % len;
            else
                p = (p + len - n % len) % len;
        end
        else if (right)
        begin
            if (p + n > len - 1)
            begin
                p   = len - 1;
                err = ERR_RIGHT;
            end
            else
                p = p + n;
        end
        else
        begin
            if (n > p)
            begin
                p   = 0;
                err = ERR_LEFT;
            end
            else
                p = p - n;
        end
        head = IDX_W'(p);
        return err;
    endfunction

    function automatic tape_result_t tape_step(logic [REQ_W-1:0] req, logic [DATA_W-1:0] amt,
                                               logic [DATA_W-1:0] val, logic eof);
        logic [DATA_W-1:0] mask;
        tape_result_t      r;
        mask = width_mask();
        r    = '0;
        case (req)
            REQ_ADD:   tape_mirror[head] = (tape_mirror[head] + amt) & mask;
            REQ_SUB:   tape_mirror[head] = (tape_mirror[head] - amt) & mask;
            REQ_RIGHT: r.err = move_head(1'b1, amt);
            REQ_LEFT:  r.err = move_head(1'b0, amt);
            REQ_STORE: tape_mirror[head] = eof ? (eof_reg ? mask : '0) : (val & mask);
            REQ_EMIT:  r.strobe = 1'b1;
            default:   ;
        endcase
        r.cval = tape_mirror[head] & mask;
        r.pos  = PTR_OUT_W'(head);
        return r;
    endfunction

    function automatic dir_row_t row_word(logic [REQ_W-1:0] req, logic [DATA_W-1:0] amt,
                                          logic [DATA_W-1:0] val, logic eof);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_WORD;
        r.req  = req;
        r.amt  = amt;
        r.val  = val;
        r.eof  = eof;
        return r;
    endfunction

    function automatic dir_row_t row_chk(logic [REQ_W-1:0] req, logic [DATA_W-1:0] amt,
                                         logic [DATA_W-1:0] val, logic eof,
                                         logic [DATA_W-1:0] cval, logic [PTR_OUT_W-1:0] pos,
                                         logic [ERR_W-1:0] err, logic strobe);
        dir_row_t r;
        r             = row_word(req, amt, val, eof);
        r.chk         = 1'b1;
        r.want.cval   = cval;
        r.want.pos    = pos;
        r.want.err    = err;
        r.want.strobe = strobe;
        return r;
    endfunction

    function automatic dir_row_t row_cfg(logic [1:0] idx, logic [DATA_W-1:0] v);
        dir_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.val     = v;
        return r;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TAPE_LENGTH: len_reg  = v[CFG_LEN_W-1:0];
            REG_TAPE_MODE:   wrap_reg = v[0];
            REG_EOF_MODE:    eof_reg  = v[0];
            default:         cw_reg   = v[CW_W-1:0];
        endcase
        n_reg_writes++;
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic hold_for_results();
        if (result_q.size() != 0)
        begin
            in_valid <= 1'b0;
            while (result_q.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] amt,
                             input logic [DATA_W-1:0] val, input logic eof,
                             input logic has_want, input tape_result_t typed);
        tape_result_t r;
        while (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        amount   <= amt;
        in_value <= val;
        at_eof   <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = tape_step(req, amt, val, eof);
        result_q.push_back(has_want ? typed : r);
        n_words++;
    endtask

    task automatic pick_word(output logic [REQ_W-1:0] req, output logic [DATA_W-1:0] amt,
                             output logic [DATA_W-1:0] val, output logic eof);
        int unsigned len;
        int unsigned sel;
        len = cells_in_use();
        sel = $urandom_range(0, 99);
        if (sel < 18)      req = REQ_ADD;
        else if (sel < 32) req = REQ_SUB;
        else if (sel < 52) req = REQ_RIGHT;
        else if (sel < 72) req = REQ_LEFT;
        else if (sel < 86) req = REQ_STORE;
        else if (sel < 96) req = REQ_EMIT;
        else               req = $urandom_range(0, 1) ? REQ_SPARE7 : REQ_SPARE6;
        if (req == REQ_RIGHT || req == REQ_LEFT)
        begin
            case ($urandom_range(0, 9))
                0:       amt = '0;
                1:       amt = {1'b1, 31'($urandom())};
                2:       amt = $urandom();
                3:       amt = len - 1 + $urandom_range(0, 2);
                default: amt = $urandom_range(1, (len + 3) / 2 + 1);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       amt = $urandom_range(0, 3);
                1:       amt = 32'h8000_0000;
                2:       amt = 32'h7FFF_FFFF;
                3:       amt = 32'hFFFF_FFFF;
                default: amt = $urandom();
            endcase
        end
        val = $urandom();
        eof = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_phase(input int len, input logic wrap, input logic eof_all_ones,
                             input logic [CW_W-1:0] cw, input int snd, input int rcv,
                             input int count);
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] amt;
        logic [DATA_W-1:0] val;
        logic              eof;
        settle_idle();
        reg_write(REG_TAPE_LENGTH, len);
        reg_write(REG_TAPE_MODE, DATA_W'(wrap));
        reg_write(REG_EOF_MODE, DATA_W'(eof_all_ones));
        reg_write(REG_CELL_WIDTH, DATA_W'(cw));
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        repeat (count)
        begin
            pick_word(req, amt, val, eof);
            if ($urandom_range(0, 39) == 0)
                hold_for_results();
            send_word(req, amt, val, eof, 1'b0, '0);
        end
    endtask

    task automatic build_directed();
        dir_tab.push_back(row_chk(REQ_EMIT, 32'd0, 32'd0, 1'b0, 32'h0, 12'd0, ERR_NONE, 1'b1));
        dir_tab.push_back(row_chk(REQ_LEFT, 32'd0, 32'd0, 1'b0, 32'h0, 12'd0, ERR_LEFT, 1'b0));
        dir_tab.push_back(row_chk(REQ_ADD, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'hFF, 12'd0,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_ADD, 32'd1, 32'd0, 1'b0, 32'h0, 12'd0, ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_SUB, 32'd1, 32'd0, 1'b0, 32'hFF, 12'd0, ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_SUB, 32'h8000_0000, 32'd0, 1'b0, 32'hFF, 12'd0,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_RIGHT, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'h0, 12'd4095,
                                  ERR_RIGHT, 1'b0));
        dir_tab.push_back(row_chk(REQ_STORE, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'hFF, 12'd4095,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_STORE, 32'd0, 32'hA5, 1'b1, 32'h0, 12'd4095,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,
                                  12'd4095, ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_SPARE7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,
                                  12'd4095, ERR_NONE, 1'b0));
        dir_tab.push_back(row_chk(REQ_RIGHT, 32'hFFFF_FFFB, 32'd0, 1'b0, 32'h0, 12'd4095,
                                  ERR_RIGHT, 1'b0));
        dir_tab.push_back(row_chk(REQ_LEFT, 32'd4095, 32'd0, 1'b0, 32'hFF, 12'd0,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_cfg(REG_CELL_WIDTH, DATA_W'(CW_SPARE)));
        dir_tab.push_back(row_word(REQ_ADD, 32'h8000_0000, 32'd0, 1'b0));
        dir_tab.push_back(row_cfg(REG_EOF_MODE, 32'd1));
        dir_tab.push_back(row_chk(REQ_STORE, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 12'd0,
                                  ERR_NONE, 1'b0));
        dir_tab.push_back(row_cfg(REG_CELL_WIDTH, DATA_W'(CW_16)));
        dir_tab.push_back(row_chk(REQ_EMIT, 32'd0, 32'd0, 1'b0, 32'hFFFF, 12'd0,
                                  ERR_NONE, 1'b1));
        dir_tab.push_back(row_chk(REQ_ADD, 32'd1, 32'd0, 1'b0, 32'h0, 12'd0, ERR_NONE, 1'b0));
        dir_tab.push_back(row_cfg(REG_TAPE_MODE, 32'd1));
        dir_tab.push_back(row_cfg(REG_TAPE_LENGTH, 32'd0));
        dir_tab.push_back(row_word(REQ_RIGHT, 32'd3, 32'd0, 1'b0));
        dir_tab.push_back(row_cfg(REG_TAPE_LENGTH, 32'd8191));
        dir_tab.push_back(row_word(REQ_LEFT, 32'd1, 32'd0, 1'b0));
        dir_tab.push_back(row_word(REQ_RIGHT, 32'h7FFF_FFFF, 32'd0, 1'b0));
        dir_tab.push_back(row_cfg(REG_TAPE_LENGTH, 32'd10));
        dir_tab.push_back(row_word(REQ_EMIT, 32'd0, 32'd0, 1'b0));
        dir_tab.push_back(row_word(REQ_RIGHT, 32'd0, 32'd0, 1'b0));
        dir_tab.push_back(row_cfg(REG_TAPE_MODE, 32'd0));
        dir_tab.push_back(row_word(REQ_RIGHT, 32'd2000, 32'd0, 1'b0));
        dir_tab.push_back(row_word(REQ_STORE, 32'd0, 32'h1234_5678, 1'b0));
        dir_tab.push_back(row_word(REQ_LEFT, 32'h8000_0000, 32'd0, 1'b0));
    endtask

    // result side: random stall, compare against oldest expectation
    always @(posedge clk)
    begin
        tape_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (range_error != ERR_NONE)
                n_range_errs++;
            if (emit_strobe)
                n_emits++;
            if (result_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR %0t: unexpected word cell=%h pos=%0d err=%0d emit=%0b",
                             $realtime, cell_value, pointer_pos, range_error, emit_strobe);
            end
            else
            begin
                want = result_q.pop_front();
                if (cell_value !== want.cval || pointer_pos !== want.pos ||
                    range_error !== want.err || emit_strobe !== want.strobe)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR %0t: cell %h/%h pos %0d/%0d err %0d/%0d emit %0b/%0b",
                                 $realtime, cell_value, want.cval, pointer_pos, want.pos,
                                 range_error, want.err, emit_strobe, want.strobe);
                end
            end
        end
        out_stall <= (rcv_stall_pct > 0) && ($urandom_range(0, 99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        req_type = REQ_ADD;
        amount   = '0;
        in_value = '0;
        at_eof   = 1'b0;
        foreach (tape_mirror[i])
            tape_mirror[i] = '0;
        head     = '0;
        len_reg  = TAPE_LENGTH_RST;
        wrap_reg = 1'b0;
        eof_reg  = 1'b0;
        cw_reg   = CW_8;
        build_directed();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                settle_idle();
                reg_write(dir_tab[i].reg_idx, dir_tab[i].val);
            end
            else
                send_word(dir_tab[i].req, dir_tab[i].amt, dir_tab[i].val, dir_tab[i].eof,
                          dir_tab[i].chk, dir_tab[i].want);
        end

        run_phase(16,   1'b0, 1'b0, CW_8,     0,  0,  100);
        run_phase(1,    1'b1, 1'b1, CW_16,    48, 0,  60);
        run_phase(4096, 1'b1, 1'b0, CW_32,    0,  48, 100);
        run_phase(300,  1'b0, 1'b1, CW_SPARE, 25, 25, 100);
        run_phase(7,    1'b1, 1'b1, CW_8,     0,  0,  80);
        run_phase(8191, 1'b0, 1'b0, CW_16,    48, 0,  80);
        run_phase(0,    1'b0, 1'b1, CW_32,    0,  48, 40);
        run_phase(2,    1'b1, 1'b0, CW_8,     25, 25, 60);

        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d words, checked %0d results over %0d register writes",
                 n_words, n_results, n_reg_writes);
        $display("Seen %0d range errors and %0d emits; %0d mismatches",
                 n_range_errs, n_emits, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ bf_data_tape_unit.f @@
sv/bfdt_pkg.sv
sv/bfdt_alu.sv
sv/bf_data_tape_unit.sv
tb/tb_bf_data_tape_unit.sv
